>>> sv/rse_pkg.sv
// Shared constants, types and segment lookup functions for the readout segment encoder.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

    // Register map: word index within the configuration space.
    typedef enum logic {
        t_reg_special_code = 1'b0,
        t_reg_unmapped     = 1'b1
    } t_reg_idx;

    localparam int unsigned PaddrWidth = 3;
    localparam int unsigned PdataWidth = 32;

    localparam logic [15:0] DigitLimit       = 16'd3000;
    localparam logic [15:0] SpecialCodeReset = 16'hFFFF;
    localparam logic [15:0] DotWordPhase1    = 16'h0006;
    localparam logic [15:0] CurWordPhase0    = 16'h00C1;
    localparam logic [15:0] CurWordPhase1    = 16'h38E2;

    // Input command codes.
    localparam logic CmdRefresh = 1'b0;
    localparam logic CmdToggle  = 1'b1;

    // Control and payload of one refresh beat held between the two registers.
    typedef struct packed {
        logic        vld;
        logic [15:0] readout;
        logic        phase;
        logic        dots;
    } t_stage;

    function automatic logic [15:0] ones_word(input logic [3:0] d, input logic ph);
        logic [15:0] w0;
        logic [15:0] w1;
        begin
            w0 = 16'h0000;
            w1 = 16'h0000;
            case (d)
                4'd0: begin w0 = 16'h0039; w1 = 16'h005A; end
                4'd1: begin w0 = 16'h0031; w1 = 16'h0000; end
                4'd2: begin w0 = 16'h0029; w1 = 16'h0072; end
                4'd3: begin w0 = 16'h0039; w1 = 16'h0032; end
                4'd4: begin w0 = 16'h0031; w1 = 16'h002A; end
                4'd5: begin w0 = 16'h0019; w1 = 16'h003A; end
                4'd6: begin w0 = 16'h0019; w1 = 16'h007A; end
                4'd7: begin w0 = 16'h0039; w1 = 16'h0000; end
                4'd8: begin w0 = 16'h0039; w1 = 16'h007A; end
                4'd9: begin w0 = 16'h0039; w1 = 16'h003A; end
                default: begin w0 = 16'h0000; w1 = 16'h0000; end
            endcase
            return ph ? w1 : w0;
        end
    endfunction

    function automatic logic [15:0] tens_word(input logic [3:0] d, input logic ph);
        logic [15:0] w0;
        logic [15:0] w1;
        begin
            w0 = 16'h0000;
            w1 = 16'h0000;
            case (d)
                4'd0: begin w0 = 16'h02C1; w1 = 16'h0382; end
                4'd1: begin w0 = 16'h0000; w1 = 16'h0182; end
                4'd2: begin w0 = 16'h01C1; w1 = 16'h0302; end
                4'd3: begin w0 = 16'h0181; w1 = 16'h0382; end
                4'd4: begin w0 = 16'h0301; w1 = 16'h0182; end
                4'd5: begin w0 = 16'h0381; w1 = 16'h0282; end
                4'd6: begin w0 = 16'h03C1; w1 = 16'h0282; end
                4'd7: begin w0 = 16'h0000; w1 = 16'h0382; end
                4'd8: begin w0 = 16'h03C1; w1 = 16'h0382; end
                4'd9: begin w0 = 16'h0381; w1 = 16'h0382; end
                default: begin w0 = 16'h0000; w1 = 16'h0000; end
            endcase
            return ph ? w1 : w0;
        end
    endfunction

    function automatic logic [15:0] hundreds_word(input logic [3:0] d, input logic ph);
        logic [15:0] w0;
        logic [15:0] w1;
        begin
            w0 = 16'h0000;
            w1 = 16'h0000;
            case (d)
                4'd0: begin w0 = 16'h1C01; w1 = 16'h2C02; end
                4'd1: begin w0 = 16'h1801; w1 = 16'h0000; end
                4'd2: begin w0 = 16'h1401; w1 = 16'h3802; end
                4'd3: begin w0 = 16'h1C01; w1 = 16'h1802; end
                4'd4: begin w0 = 16'h1801; w1 = 16'h1402; end
                4'd5: begin w0 = 16'h0C01; w1 = 16'h1C02; end
                4'd6: begin w0 = 16'h0C01; w1 = 16'h3C02; end
                4'd7: begin w0 = 16'h1C01; w1 = 16'h0000; end
                4'd8: begin w0 = 16'h1C01; w1 = 16'h3C02; end
                4'd9: begin w0 = 16'h1C01; w1 = 16'h1C02; end
                default: begin w0 = 16'h0000; w1 = 16'h0000; end
            endcase
            return ph ? w1 : w0;
        end
    endfunction

    function automatic logic [15:0] thousands_word(input logic [1:0] d, input logic ph);
        logic [15:0] w0;
        logic [15:0] w1;
        begin
            w0 = 16'h0000;
            w1 = 16'h0000;
            case (d)
                2'd0: begin w0 = 16'h0000; w1 = 16'h0000; end
                2'd1: begin w0 = 16'h6001; w1 = 16'h0000; end
                2'd2: begin w0 = 16'hC001; w1 = 16'h8002; end
                default: begin w0 = 16'h0000; w1 = 16'h0000; end
            endcase
            return ph ? w1 : w0;
        end
    endfunction

endpackage : rse_pkg

`default_nettype wire

>>> sv/rse_apb_regs.sv
// APB configuration register file holding the special readout code.
`timescale 1ns / 1ps
`default_nettype none

module rse_apb_regs
    import rse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PaddrWidth-1:0] paddr,
    input  wire logic [PdataWidth-1:0] pwdata,
    output logic      [PdataWidth-1:0] prdata,
    output logic                       pready,
    output logic      [15:0]           o_special_code
);

    logic [15:0] r_code;
    t_reg_idx    reg_idx;
    logic        wr_en;

    assign reg_idx = t_reg_idx'(paddr[PaddrWidth-1]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= SpecialCodeReset;
        end else if (wr_en && (reg_idx == t_reg_special_code)) begin
            r_code <= pwdata[15:0];
        end
    end

    // The word index alone selects the register; the byte-offset bits are ignored.
    always_comb begin
        case (reg_idx)
            t_reg_special_code: prdata = {{(PdataWidth-16){1'b0}}, r_code};
            default:            prdata = {PdataWidth{1'b0}};
        endcase
    end

    assign o_special_code = r_code;

endmodule : rse_apb_regs

`default_nettype wire

>>> sv/rse_digit_enc.sv
// Decimal digit split and segment word lookup for one refresh beat.
`timescale 1ns / 1ps
`default_nettype none

module rse_digit_enc
    import rse_pkg::*;
(
    input  wire logic [15:0] i_readout,
    input  wire logic        i_phase,
    input  wire logic        i_dots,
    input  wire logic [15:0] i_special_code,
    output logic      [15:0] o_segments
);

    logic [11:0] v12;
    logic [1:0]  thou;
    logic [9:0]  rem_h;
    logic [15:0] prod_h;
    logic [3:0]  hund;
    logic [9:0]  rem_t_full;
    logic [6:0]  rem_t;
    logic [14:0] prod_t;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [3:0]  ones;
    logic [15:0] digit_word;

    always_comb begin
        v12 = i_readout[11:0];
        // Values below 3000 need at most two compares for the thousands digit.
        if (v12 >= 12'd2000) begin
            thou  = 2'd2;
            rem_h = 10'(v12 - 12'd2000);
        end else if (v12 >= 12'd1000) begin
            thou  = 2'd1;
            rem_h = 10'(v12 - 12'd1000);
        end else begin
            thou  = 2'd0;
            rem_h = v12[9:0];
        end
        // x/100 as (x*41)>>12, exact for x below 1000.
        prod_h     = 16'(rem_h) * 16'd41;
        hund       = prod_h[15:12];
        rem_t_full = rem_h - (10'(hund) * 10'd100);
        rem_t      = rem_t_full[6:0];
        // x/10 as (x*205)>>11, exact for x below 100.
        prod_t     = 15'(rem_t) * 15'd205;
        tens       = prod_t[14:11];
        ones_full  = rem_t - (7'(tens) * 7'd10);
        ones       = ones_full[3:0];

        digit_word = thousands_word(thou, i_phase) | hundreds_word(hund, i_phase)
                   | tens_word(tens, i_phase) | ones_word(ones, i_phase);

        if (i_readout < DigitLimit) begin
            o_segments = digit_word;
            if (i_dots && i_phase) begin
                o_segments = digit_word | DotWordPhase1;
            end
        end else if (i_readout == i_special_code) begin
            o_segments = i_phase ? CurWordPhase1 : CurWordPhase0;
        end else begin
            o_segments = 16'h0000;
        end
    end

endmodule : rse_digit_enc

`default_nettype wire

>>> sv/readout_segment_encoder.sv
// Top level of the readout segment encoder: input register, encoder and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block turns a 16-bit readout into the segment drive word for one phase of a
// two-phase multiplexed four-digit display. Each input beat carries a command: a refresh
// beat (i_cmd low) produces exactly one result beat with the segment word and the phase it
// belongs to, after which the phase flips; a toggle beat (i_cmd high) flips the dots flag
// and produces no result. Readouts below 3000 show as digits (plus the dot pattern on
// phase one when dots are on), a readout of 3000 or more equal to the special code shows
// the current-mode text, and anything else shows blank. The block takes one beat per
// cycle while input stall is low: a beat is captured into the input register, the digit
// split and table lookup run as combinational logic, and the word lands in the result
// register. o_out_valid rises when the beat moves on from the input register, which waits
// while the result register holds a stalled word; input stall only rises when both
// registers hold beats and the result side is stalled. The special code is written over
// the APB port at byte address 0 and resets to 65535; it should only be changed while no
// refresh beat is in flight.

module readout_segment_encoder
    import rse_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_cmd,
    input  wire logic [15:0]           i_readout,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [15:0]           o_segments,
    output logic                       o_phase,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PaddrWidth-1:0] paddr,
    input  wire logic [PdataWidth-1:0] pwdata,
    output logic      [PdataWidth-1:0] prdata,
    output logic                       pready
);

    logic        r_phase;
    logic        r_dots;
    t_stage      r_s1;
    logic        r_out_vld;
    logic [15:0] r_out_seg;
    logic        r_out_phase;

    logic [15:0] special_code;
    logic [15:0] enc_seg;
    logic        out_free;
    logic        s1_move;
    logic        in_acc;

    rse_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_special_code (special_code)
    );

    rse_digit_enc u_enc (
        .i_readout      (r_s1.readout),
        .i_phase        (r_s1.phase),
        .i_dots         (r_s1.dots),
        .i_special_code (special_code),
        .o_segments     (enc_seg)
    );

    // The result register can take a new word when empty or when its word leaves now.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_move    = r_s1.vld && out_free;
    assign o_in_stall = r_s1.vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Phase and dots are sampled at acceptance, so each refresh beat carries the state
    // that the beats before it left behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_dots    <= 1'b0;
            r_s1.vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc && (i_cmd == CmdToggle)) begin
                r_dots <= !r_dots;
            end
            if (in_acc && (i_cmd == CmdRefresh)) begin
                r_phase      <= !r_phase;
                r_s1.readout <= i_readout;
                r_s1.phase   <= r_phase;
                r_s1.dots    <= r_dots;
            end
            if (in_acc) begin
                r_s1.vld <= (i_cmd == CmdRefresh);
            end else if (s1_move) begin
                r_s1.vld <= 1'b0;
            end
            if (out_free) begin
                r_out_vld <= r_s1.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_seg   <= enc_seg;
            r_out_phase <= r_s1.phase;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_segments  = r_out_seg;
    assign o_phase     = r_out_phase;

    // A refresh beat flips the phase and leaves the dots flag alone.
    a_refresh_flips_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_acc && (i_cmd == CmdRefresh))
            |=> (r_phase != $past(r_phase)) && (r_dots == $past(r_dots)))
        else $error("refresh beat did not flip the phase");

    // A toggle beat flips the dots flag, keeps the phase and queues nothing.
    a_toggle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && in_acc && (i_cmd == CmdToggle))
            |=> (r_phase == $past(r_phase)) && (r_dots != $past(r_dots)) && !r_s1.vld)
        else $error("toggle beat changed the phase or queued a result");

    // A beat moving out of the input register appears as a result with its phase.
    a_stage_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s1_move) |=> o_out_valid && (o_phase == $past(r_s1.phase)))
        else $error("input register beat lost on its way to the output");

    // A large readout that is not the special code shows blank.
    a_blank_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s1_move && (r_s1.readout >= DigitLimit)
            && (r_s1.readout != special_code)) |=> (o_segments == 16'h0000))
        else $error("out-of-range readout did not blank the display");

endmodule : readout_segment_encoder

`default_nettype wire

>>> tb/readout_segment_encoder_test.sv
// Self-checking testbench for the readout segment encoder: directed table, then random beats.
`timescale 1ns / 1ps

// The testbench sends beats to the encoder and checks every result beat against its own
// display model. That model keeps a copy of the phase, the dots flag and the special code.
// The run has two parts. The directed part is a table that is walked in order. Its rows
// are input beats and special code writes. Where a row's segment word is obvious (the
// text pattern, blank), the word is typed into the table. Every other row is predicted by
// the model. The random part follows in several sections, and each section uses a
// different special code. The sender works in bursts with gaps between them. The receiver
// stalls on its own pattern. In one section the receiver holds off for a long stretch so
// that the block backs up. In another section the sender waits until every result has
// come. Special code writes happen only while the block is idle.
module readout_segment_encoder_test
    import rse_pkg::*;
();

    localparam int ClkHalfNs     = 5;
    localparam int ResetCycles   = 4;
    localparam int SettleCycles  = 6;     // Covers the pipeline depth with margin.
    localparam int HoldOffCycles = 80;
    localparam int BeatsPerRound = 90;
    localparam int NumRounds     = 5;

    // Display constants that the model needs, written out independently of the design.
    localparam int          NumericLimit = 3000;
    localparam logic [15:0] DotsOnPhase1 = 16'h0006;
    localparam logic [15:0] CurTextPh0   = 16'h00C1;
    localparam logic [15:0] CurTextPh1   = 16'h38E2;

    typedef enum logic {
        RowBeat,
        RowCode
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        cmd;
        logic [15:0] value;     // Readout of a beat row, or the new special code.
        bit          typed;
        logic [15:0] seg;
        logic        ph;
    } t_plan_row;

    typedef struct {
        logic [15:0] seg;
        logic        ph;
    } t_seg_beat;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = CmdRefresh;
    logic [15:0]           readout = 16'h0000;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [15:0]           segments;
    logic                  phase;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PaddrWidth-1:0] paddr = '0;
    logic [PdataWidth-1:0] pwdata = '0;
    logic [PdataWidth-1:0] prdata;
    logic                  pready;

    // Model state: the phase of the next refresh, the dots flag and the special code.
    logic        model_phase = 1'b0;
    logic        model_dots = 1'b0;
    logic [15:0] model_code = 16'hFFFF;

    t_seg_beat   pending_words[$];
    t_plan_row   plan[$];
    int          error_count = 0;
    bit          hold_req = 1'b0;
    int          burst_left = 0;

    readout_segment_encoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_readout   (readout),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_segments  (segments),
        .o_phase     (phase),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(ClkHalfNs) clk = ~clk;

    // Each lookup returns the segment words of one digit as {phase 1, phase 0}.
    function automatic logic [31:0] ones_pair(input int d);
        case (d)
            0: return {16'h005A, 16'h0039};
            1: return {16'h0000, 16'h0031};
            2: return {16'h0072, 16'h0029};
            3: return {16'h0032, 16'h0039};
            4: return {16'h002A, 16'h0031};
            5: return {16'h003A, 16'h0019};
            6: return {16'h007A, 16'h0019};
            7: return {16'h0000, 16'h0039};
            8: return {16'h007A, 16'h0039};
            default: return {16'h003A, 16'h0039};
        endcase
    endfunction

    function automatic logic [31:0] tens_pair(input int d);
        case (d)
            0: return {16'h0382, 16'h02C1};
            1: return {16'h0182, 16'h0000};
            2: return {16'h0302, 16'h01C1};
            3: return {16'h0382, 16'h0181};
            4: return {16'h0182, 16'h0301};
            5: return {16'h0282, 16'h0381};
            6: return {16'h0282, 16'h03C1};
            7: return {16'h0382, 16'h0000};
            8: return {16'h0382, 16'h03C1};
            default: return {16'h0382, 16'h0381};
        endcase
    endfunction

    function automatic logic [31:0] hundreds_pair(input int d);
        case (d)
            0: return {16'h2C02, 16'h1C01};
            1: return {16'h0000, 16'h1801};
            2: return {16'h3802, 16'h1401};
            3: return {16'h1802, 16'h1C01};
            4: return {16'h1402, 16'h1801};
            5: return {16'h1C02, 16'h0C01};
            6: return {16'h3C02, 16'h0C01};
            7: return {16'h0000, 16'h1C01};
            8: return {16'h3C02, 16'h1C01};
            default: return {16'h1C02, 16'h1C01};
        endcase
    endfunction

    function automatic logic [31:0] thousands_pair(input int d);
        case (d)
            0: return {16'h0000, 16'h0000};
            1: return {16'h0000, 16'h6001};
            default: return {16'h8002, 16'hC001};
        endcase
    endfunction

    // Segment word for one refresh. A numeric value is shown as digits, and the dot
    // pattern is added only to numeric values.
    function automatic logic [15:0] segment_word(input logic [15:0] v, input logic ph,
                                                 input logic dots, input logic [15:0] code);
        int          n;
        logic [31:0] acc;
        n = int'(v);
        if (n < NumericLimit) begin
            acc = thousands_pair(n / 1000) | hundreds_pair((n % 1000) / 100) |
                  tens_pair((n % 100) / 10) | ones_pair(n % 10);
            if (dots) acc = acc | {DotsOnPhase1, 16'h0000};
            return ph ? acc[31:16] : acc[15:0];
        end
        if (v == code) return ph ? CurTextPh1 : CurTextPh0;
        return 16'h0000;
    endfunction

    function automatic void add_beat(input logic c, input logic [15:0] v);
        t_plan_row row;
        row = '{kind: RowBeat, cmd: c, value: v, typed: 1'b0, seg: 16'h0000, ph: 1'b0};
        plan.push_back(row);
    endfunction

    function automatic void add_typed(input logic [15:0] v, input logic [15:0] s,
                                      input logic p);
        t_plan_row row;
        row = '{kind: RowBeat, cmd: CmdRefresh, value: v, typed: 1'b1, seg: s, ph: p};
        plan.push_back(row);
    endfunction

    function automatic void add_code(input logic [15:0] code);
        t_plan_row row;
        row = '{kind: RowCode, cmd: CmdRefresh, value: code, typed: 1'b0, seg: 16'h0000,
                ph: 1'b0};
        plan.push_back(row);
    endfunction

    // Drops valid for the given number of cycles.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Sender bursts: once a burst runs out, a random gap is inserted and a new burst
    // length is drawn. Some gaps are zero, so that bursts also follow each other back to back.
    task automatic burst_gap();
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
        end
        burst_left = burst_left - 1;
    endtask

    // Offers one beat and holds it until it is accepted. The model is updated at the edge
    // that accepts the beat. A typed expectation replaces the model's word for that beat.
    task automatic send_beat(input logic c, input logic [15:0] v, input bit typed,
                             input logic [15:0] tseg, input logic tph);
        t_seg_beat w;
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= c;
        readout  <= v;
        do @(posedge clk); while (in_stall);
        if (c == CmdToggle) begin
            model_dots = ~model_dots;
        end else begin
            w.seg = typed ? tseg : segment_word(v, model_phase, model_dots, model_code);
            w.ph  = typed ? tph : model_phase;
            pending_words.push_back(w);
            model_phase = ~model_phase;
        end
    endtask

    // Lowers valid and waits until every expected word has come. The extra cycles let a
    // trailing toggle beat, which produces no result, clear the pipeline.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Writes the special code and reads it back. This is only called while the block is idle.
    task automatic write_code(input logic [15:0] code);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PaddrWidth'({t_reg_special_code, 2'b00});
        pwdata  <= {16'h0000, code};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model_code = code;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== code) begin
            $display("%0t: special code read back: expected %h, actual %h",
                     $time, code, prdata[15:0]);
            error_count = error_count + 1;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: every accepted result beat is compared with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result beat: segments %h phase %b",
                         $time, segments, phase);
                error_count = error_count + 1;
            end else begin
                if (segments !== pending_words[0].seg) begin
                    $display("%0t: segments: expected %h, actual %h",
                             $time, pending_words[0].seg, segments);
                    error_count = error_count + 1;
                end
                if (phase !== pending_words[0].ph) begin
                    $display("%0t: phase: expected %b, actual %b",
                             $time, pending_words[0].ph, phase);
                    error_count = error_count + 1;
                end
                void'(pending_words.pop_front());
            end
        end
    end

    // The receiver's stall pattern. Each stretch uses one of several modes: no stall,
    // random stall, every other cycle, or stall bursts. A hold-off request keeps stall
    // high for a long counted stretch, so that the pipeline fills and the input stalls.
    initial begin
        forever begin : rx_stretch
            int mode;
            int len;
            int held;
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 40);
            for (int k = 0; k < len; k++) begin
                @(negedge clk);
                if (hold_req) begin
                    out_stall <= 1'b1;
                    for (held = 1; held < HoldOffCycles; held++) @(negedge clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 1) == 1);
                        2: out_stall <= k[0];
                        default: out_stall <= ((k % 8) < 5);
                    endcase
                end
            end
        end
    end

    // Safety limit. The slowest correct run is far below this.
    initial begin
        #5ms;
        $display("readout_segment_encoder_test: FAIL");
        $finish;
    end

    initial begin
        logic [15:0] round_code [NumRounds];
        logic        c;
        logic [15:0] v;
        int          pick;

        // Directed table. The reset state is phase 0, dots off and special code 65535.
        // The phase in the typed rows follows from the refresh rows above them.
        add_typed(16'hFFFF, CurTextPh0, 1'b0);   // Text pattern at the reset code.
        add_typed(16'hFFFF, CurTextPh1, 1'b1);
        add_typed(16'd3000, 16'h0000, 1'b0);     // First value above the numeric range.
        add_typed(16'hFFFE, 16'h0000, 1'b1);
        add_beat(CmdRefresh, 16'd0);
        add_beat(CmdRefresh, 16'd2999);
        add_beat(CmdToggle, 16'hFFFF);           // Dots on. The phase stays where it is.
        add_beat(CmdRefresh, 16'd0);
        add_beat(CmdRefresh, 16'd1000);
        add_typed(16'd3000, 16'h0000, 1'b0);     // Blank gets no dots.
        add_typed(16'hFFFF, CurTextPh1, 1'b1);   // The text pattern gets no dots either.
        add_beat(CmdToggle, 16'h0000);           // Dots off again.
        add_beat(CmdRefresh, 16'd2345);
        add_beat(CmdRefresh, 16'd1876);
        add_code(16'd3000);                      // Lowest code that can show the text pattern.
        add_typed(16'd3000, CurTextPh0, 1'b0);
        add_typed(16'hFFFF, 16'h0000, 1'b1);     // The old code now shows blank.
        add_beat(CmdRefresh, 16'd2999);
        add_code(16'd1234);                      // Code inside the numeric range.
        add_beat(CmdRefresh, 16'd1234);          // Shown as digits, not as text.
        add_beat(CmdRefresh, 16'd1234);
        add_code(16'd0);
        add_beat(CmdRefresh, 16'd0);
        add_typed(16'hAAAA, 16'h0000, 1'b0);
        add_typed(16'h5555, 16'h0000, 1'b1);
        add_beat(CmdRefresh, 16'd567);
        add_beat(CmdRefresh, 16'd89);

        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == RowCode) begin
                drain();
                write_code(plan[i].value);
            end else begin
                burst_gap();
                send_beat(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].seg,
                          plan[i].ph);
            end
        end

        // Random sections. Each one starts from an idle block with a new special code: the
        // two ends of the range that can show text, a random code between them, a code that
        // can never show text, and a code drawn from the whole register range.
        round_code[0] = 16'hFFFF;
        round_code[1] = 16'd3000;
        round_code[2] = 16'($urandom_range(3001, 65534));
        round_code[3] = 16'($urandom_range(0, 2999));
        round_code[4] = 16'($urandom_range(0, 65535));
        for (int r = 0; r < NumRounds; r++) begin
            drain();
            write_code(round_code[r]);
            for (int n = 0; n < BeatsPerRound; n++) begin
                if (r == 1 && n == 30) hold_req = 1'b1;
                if (r == 2 && n == 45) drain();
                burst_gap();
                pick = $urandom_range(0, 99);
                c = CmdRefresh;
                v = 16'($urandom);
                if (pick < 12) begin
                    c = CmdToggle;
                end else if (pick < 50) begin
                    v = 16'($urandom_range(0, NumericLimit - 1));
                end else if (pick < 60) begin
                    case ($urandom_range(0, 5))
                        0: v = 16'd0;
                        1: v = 16'd999;
                        2: v = 16'd1000;
                        3: v = 16'd2999;
                        4: v = 16'd3000;
                        default: v = 16'd3001;
                    endcase
                end else if (pick < 75) begin
                    v = model_code;
                end
                send_beat(c, v, 1'b0, 16'h0000, 1'b0);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("readout_segment_encoder_test: PASS");
        end else begin
            $display("readout_segment_encoder_test: FAIL");
        end
        $finish;
    end

endmodule : readout_segment_encoder_test

>>> readout_segment_encoder.f
sv/rse_pkg.sv
sv/rse_apb_regs.sv
sv/rse_digit_enc.sv
sv/readout_segment_encoder.sv
tb/readout_segment_encoder_test.sv
